@@ rtl/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants of the scancode translator
// Scancode values, output character codes and the structs that pass
// between the translator stages.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int KEYMAP_ENTRIES = 128;

	// input word layout
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;

	// input kind carried in tuser
	localparam logic MODE_KEY   = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// keymap selector codes
	localparam logic [1:0] MAP_UNSHIFTED = 2'd0;
	localparam logic [1:0] MAP_SHIFTED   = 2'd1;
	localparam logic [1:0] MAP_ALT       = 2'd2;

	// set-1 make codes
	localparam logic [7:0] SC_LSHIFT = 8'd42;
	localparam logic [7:0] SC_RSHIFT = 8'd54;
	localparam logic [7:0] SC_LCTRL  = 8'd29;
	localparam logic [7:0] SC_LALT   = 8'd56;
	localparam logic [7:0] SC_DELETE = 8'd83;
	localparam logic [7:0] SC_PGUP   = 8'd73;
	localparam logic [7:0] SC_PGDN   = 8'd81;
	localparam logic [7:0] SC_UP     = 8'd72;
	localparam logic [7:0] SC_DOWN   = 8'd80;
	localparam logic [7:0] SC_RIGHT  = 8'd77;
	localparam logic [7:0] SC_LEFT   = 8'd75;
	localparam logic [7:0] SC_HOME   = 8'd71;
	localparam logic [7:0] SC_END    = 8'd79;

	localparam logic [7:0] RELEASE_MASK = 8'h80;
	localparam logic [7:0] CTRL_MASK    = 8'h1f;

	// characters
	localparam logic [7:0] CH_ESC     = 8'h1b;
	localparam logic [7:0] CH_BRACKET = 8'h5b;
	localparam logic [7:0] CH_TILDE   = 8'h7e;
	localparam logic [7:0] CH_A       = 8'h41;
	localparam logic [7:0] CH_B       = 8'h42;
	localparam logic [7:0] CH_C       = 8'h43;
	localparam logic [7:0] CH_D       = 8'h44;
	localparam logic [7:0] CH_F       = 8'h46;
	localparam logic [7:0] CH_H       = 8'h48;
	localparam logic [7:0] CH_Z       = 8'h5a;
	localparam logic [7:0] CH_3       = 8'h33;
	localparam logic [7:0] CH_5       = 8'h35;
	localparam logic [7:0] CH_6       = 8'h36;
	localparam logic [7:0] CH_NUL     = 8'h00;

	// scancode item held in the first stage, with modifiers as seen before it
	typedef struct packed {
		logic       mode;
		logic       from_aux;
		logic [7:0] scancode;
		logic       shift;
		logic       ctrl;
		logic       alt;
	} item_t;

	// up to four output bytes made from one scancode
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            reboot;
		logic            has;
	} burst_t;

endpackage

@@ rtl/sat_keymap.sv @@
// ----------------------------------------------------------------------------
// sat_keymap: loadable keymap tables
// Three keymaps (unshifted, shifted, alt), one write port shared by all,
// each read at the same address with registered read data.
// ----------------------------------------------------------------------------
module sat_keymap #(
	parameter int ENTRIES = sat_pkg::KEYMAP_ENTRIES
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [1:0]                 wr_sel,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  logic [7:0]                 wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output logic [7:0]                 unshifted_s1,
	output logic [7:0]                 shifted_s1,
	output logic [7:0]                 alted_s1
);
	import sat_pkg::*;

	logic [7:0] unshifted_mem [ENTRIES];
	logic [7:0] shifted_mem   [ENTRIES];
	logic [7:0] alted_mem     [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en && wr_sel == MAP_UNSHIFTED) begin
			unshifted_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			unshifted_s1 <= unshifted_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_sel == MAP_SHIFTED) begin
			shifted_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			shifted_s1 <= shifted_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_sel == MAP_ALT) begin
			alted_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			alted_s1 <= alted_mem[rd_addr];
		end
	end

endmodule

@@ rtl/sat_decode.sv @@
// ----------------------------------------------------------------------------
// sat_decode: scancode to byte burst
// Turns one registered scancode and its keymap entries into zero to four
// output bytes.
// ----------------------------------------------------------------------------
module sat_decode (
	input  sat_pkg::item_t  item,
	input  logic [7:0]      unshifted,
	input  logic [7:0]      shifted,
	input  logic [7:0]      alted,
	output sat_pkg::burst_t burst
);
	import sat_pkg::*;

	logic [7:0] pick;

	function automatic burst_t ansi_seq(input logic [7:0] code, input logic tilde);
		burst_t b;
		b          = '0;
		b.bytes[0] = CH_ESC;
		b.bytes[1] = CH_BRACKET;
		b.bytes[2] = code;
		b.bytes[3] = CH_TILDE;
		b.last_idx = tilde ? 2'd3 : 2'd2;
		b.has      = 1'b1;
		return b;
	endfunction

	// plain key: alt map, then shifted, then unshifted
	always_comb begin
		if (item.alt) begin
			pick = alted;
		end else if (item.shift) begin
			pick = shifted;
		end else begin
			pick = unshifted;
		end
	end

	always_comb begin
		burst = '0;
		if (item.mode == MODE_KEY && !item.from_aux && !item.scancode[7]) begin
			unique case (item.scancode)
				SC_LSHIFT, SC_RSHIFT, SC_LCTRL, SC_LALT: begin
					burst = '0;
				end
				SC_UP:    burst = ansi_seq(CH_A, 1'b0);
				SC_DOWN:  burst = ansi_seq(CH_B, 1'b0);
				SC_RIGHT: burst = ansi_seq(CH_C, 1'b0);
				SC_LEFT:  burst = ansi_seq(CH_D, 1'b0);
				SC_HOME:  burst = ansi_seq(CH_H, 1'b0);
				SC_END:   burst = ansi_seq(CH_F, 1'b0);
				SC_PGUP:  burst = ansi_seq(CH_5, 1'b1);
				SC_PGDN:  burst = ansi_seq(CH_6, 1'b1);
				SC_DELETE: begin
					if (item.ctrl && item.alt) begin
						burst          = '0;
						burst.bytes[0] = CH_NUL;
						burst.reboot   = 1'b1;
						burst.has      = 1'b1;
					end else begin
						burst = ansi_seq(CH_3, 1'b1);
					end
				end
				default: begin
					if (item.ctrl && shifted >= CH_A && shifted <= CH_Z) begin
						burst.bytes[0] = shifted & CTRL_MASK;
						burst.has      = 1'b1;
					end else begin
						burst.bytes[0] = pick;
						burst.has      = !pick[7];
					end
				end
			endcase
		end
	end

endmodule

@@ rtl/sat_out_buf.sv @@
// ----------------------------------------------------------------------------
// sat_out_buf: output burst register
// Holds one burst, handing its bytes to the output one per cycle while ready.
// ----------------------------------------------------------------------------
module sat_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  sat_pkg::burst_t burst,
	output logic            free,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // character
	output logic            m_axis_tlast,
	output logic            m_axis_tuser   // reboot_request
);
	import sat_pkg::*;

	logic       valid_q;
	logic [1:0] ptr_q;
	burst_t     burst_s2;
	logic       take;
	logic       done;

	assign take = valid_q && m_axis_tready;
	assign done = take && ptr_q == burst_s2.last_idx;
	assign free = !valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ptr_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			ptr_q   <= 2'd0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (take) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_s2 <= burst;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = burst_s2.bytes[ptr_q];
	assign m_axis_tlast  = ptr_q == burst_s2.last_idx;
	assign m_axis_tuser  = burst_s2.reboot;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("burst loaded over one still in flight");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ptr_q <= burst_s2.last_idx)
		else $error("byte pointer past end of burst");

	a_reboot_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && burst_s2.reboot |-> m_axis_tlast && m_axis_tdata == CH_NUL)
		else $error("reboot word not a lone nul byte");

	a_ptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !done && !load |=> valid_q && ptr_q == $past(ptr_q) + 2'd1)
		else $error("byte pointer did not advance after a taken word");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q && ptr_q == 2'd0)
		else $error("new burst does not start at its first byte");

endmodule

@@ rtl/scancode_to_ansi_translator_core.sv @@
// ----------------------------------------------------------------------------
// scancode_to_ansi_translator_core: set-1 scancode to ascii / ansi translator
// path: first stage registers the accepted word, output buffer its burst
// throughput: one input word per cycle while each makes at most one output
//   word and the output is ready; an item making n words holds the output
//   register till its last is taken (cursor keys 3 words, page keys, delete 4)
// reset: asynchronous, clears the modifier flags and the stage valid bits;
//   keymap contents are kept and hold garbage until written
// ----------------------------------------------------------------------------
module scancode_to_ansi_translator_core #(
	parameter int KEYMAP_ENTRIES = sat_pkg::KEYMAP_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// scancode / keymap write stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// scancode[7:0], table_select[9:8], table_index[16:10],
	// table_value[24:17], zero[31:25]
	input  logic [sat_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// mode[0], from_aux[1]
	input  logic [sat_pkg::S_TUSER_W-1:0] s_axis_tuser,
	// character stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // character[7:0]
	output logic                          m_axis_tlast,
	output logic                          m_axis_tuser   // reboot_request[0]
);
	import sat_pkg::*;

	localparam int AW = $clog2(KEYMAP_ENTRIES);

	// unpacked input word
	logic       in_mode;
	logic       in_aux;
	logic [7:0] in_scancode;
	logic [1:0] in_table_select;
	logic [6:0] in_table_index;
	logic [7:0] in_table_value;

	logic       accept;
	logic       key_in;    // scancode byte that can touch the modifiers
	logic [6:0] rel_code;

	// modifier flags, already updated for every accepted key word
	logic       shift_q;
	logic       ctrl_q;
	logic       alt_q;

	// first stage: item plus modifiers as they stood before it
	logic       s1_valid_q;
	item_t      item_s1;
	logic [7:0] unshifted_s1;
	logic [7:0] shifted_s1;
	logic [7:0] alted_s1;
	logic       s1_adv;

	burst_t     burst;
	logic       ob_free;
	logic       ob_load;

	assign in_mode         = s_axis_tuser[0];
	assign in_aux          = s_axis_tuser[1];
	assign in_scancode     = s_axis_tdata[7:0];
	assign in_table_select = s_axis_tdata[9:8];
	assign in_table_index  = s_axis_tdata[16:10];
	assign in_table_value  = s_axis_tdata[24:17];

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign key_in   = accept && in_mode == MODE_KEY && !in_aux;
	assign rel_code = in_scancode[6:0];

	// first stage drains when its burst is empty or the output buffer takes it
	assign s1_adv        = s1_valid_q && (!burst.has || ob_free);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign ob_load       = s1_valid_q && burst.has && ob_free;

	// modifier tracking: press sets, release clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ctrl_q  <= 1'b0;
			alt_q   <= 1'b0;
		end else if (key_in) begin
			if ((in_scancode & RELEASE_MASK) != 8'd0) begin
				priority if (rel_code == SC_LSHIFT[6:0] || rel_code == SC_RSHIFT[6:0]) begin
					shift_q <= 1'b0;
				end else if (rel_code == SC_LCTRL[6:0]) begin
					ctrl_q <= 1'b0;
				end else if (rel_code == SC_LALT[6:0]) begin
					alt_q <= 1'b0;
				end else begin
					shift_q <= shift_q;
				end
			end else begin
				priority if (in_scancode == SC_LSHIFT || in_scancode == SC_RSHIFT) begin
					shift_q <= 1'b1;
				end else if (in_scancode == SC_LCTRL) begin
					ctrl_q <= 1'b1;
				end else if (in_scancode == SC_LALT) begin
					alt_q <= 1'b1;
				end else begin
					shift_q <= shift_q;
				end
			end
		end
	end

	// first stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// first stage payload, captured with the modifiers before this word's update
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.mode     <= in_mode;
			item_s1.from_aux <= in_aux;
			item_s1.scancode <= in_scancode;
			item_s1.shift    <= shift_q;
			item_s1.ctrl     <= ctrl_q;
			item_s1.alt      <= alt_q;
		end
	end

	// keymaps: written and read at the accept edge so a write is seen by the
	// very next scancode
	sat_keymap #(
		.ENTRIES (KEYMAP_ENTRIES)
	) u_keymap (
		.clk          (clk),
		.wr_en        (accept && in_mode == MODE_WRITE),
		.wr_sel       (in_table_select),
		.wr_addr      (in_table_index[AW-1:0]),
		.wr_data      (in_table_value),
		.rd_en        (accept),
		.rd_addr      (in_scancode[AW-1:0]),
		.unshifted_s1 (unshifted_s1),
		.shifted_s1   (shifted_s1),
		.alted_s1     (alted_s1)
	);

	sat_decode u_decode (
		.item      (item_s1),
		.unshifted (unshifted_s1),
		.shifted   (shifted_s1),
		.alted     (alted_s1),
		.burst     (burst)
	);

	sat_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (ob_load),
		.burst         (burst),
		.free          (ob_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_axis_tready)
		else $error("input stalled with an empty first stage");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(item_s1))
		else $error("first stage item lost while stalled");

	a_silent_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !burst.has |-> s1_adv && !ob_load)
		else $error("empty burst not dropped");

endmodule
